@@ hw/rtl/mct_pkg.sv @@
// Shared types, codes and arithmetic helpers for the congruence transform block.
package mct_pkg;

	// op codes carried on the input tuser
	localparam logic [1:0] OP_LOAD_M = 2'd0;
	localparam logic [1:0] OP_LOAD_C = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;

	// configuration register indexes
	localparam logic REG_SO_COUNT = 1'b0;
	localparam logic REG_MO_COUNT = 1'b1;

	localparam logic [3:0] SIZE_RESET = 4'd8;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// exact accumulator: 64-bit products, up to 64 terms, plus headroom
	localparam int ACC_W = 72;

	typedef enum logic [1:0] {
		CMD_LOAD_M,
		CMD_LOAD_C,
		CMD_START
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
	} cmd_t;

	// floor shift right 16, then saturate to signed 32 bits
	function automatic logic signed [31:0] sat_shift(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-48:0] hi;
		logic signed [31:0] res;
		hi = a[ACC_W-1:47];
		if ((&hi) || !(|hi))
			res = a[47:16];
		else if (a[ACC_W-1])
			res = 32'sh8000_0000;
		else
			res = 32'sh7FFF_FFFF;
		return res;
	endfunction

endpackage

@@ hw/rtl/mct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/mct_front.sv @@
// Intake: accepts input items, decodes op, drops unused codes and out-of-range loads.
module mct_front #(
	parameter int MAX_DIM = 8
) (
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [1:0]    s_axis_tuser,   // [1:0] op
	input  logic [39:0]   s_axis_tdata,   // [2:0] row, [5:3] col, [37:6] value
	input  logic          q_full,
	output logic          q_push,
	output mct_pkg::cmd_t q_cmd
);

	import mct_pkg::*;

	logic keep;
	logic in_range;

	assign in_range = (32'(s_axis_tdata[2:0]) < MAX_DIM) && (32'(s_axis_tdata[5:3]) < MAX_DIM);

	always_comb begin
		q_cmd.row   = s_axis_tdata[2:0];
		q_cmd.col   = s_axis_tdata[5:3];
		q_cmd.value = s_axis_tdata[37:6];
		q_cmd.kind  = CMD_START;
		keep        = 1'b0;
		unique case (s_axis_tuser)
			OP_LOAD_M: begin
				q_cmd.kind = CMD_LOAD_M;
				keep       = in_range;
			end
			OP_LOAD_C: begin
				q_cmd.kind = CMD_LOAD_C;
				keep       = in_range;
			end
			OP_START: begin
				q_cmd.kind = CMD_START;
				keep       = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// dropped items are still taken, they simply never reach the queue
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

@@ hw/rtl/mct_fifo.sv @@
// Short command queue between intake and compute engine.
module mct_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mct_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output mct_pkg::cmd_t head
);

	import mct_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   count_q;

	assign valid = (count_q != '0);
	assign full  = (count_q == (QW+1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QW+1)'(1);
			end
		end
	end

endmodule

@@ hw/rtl/mct_back.sv @@
// Compute engine: executes queued loads, runs T = M C then R = C^T T, emits R.
module mct_back #(
	parameter int MAX_DIM = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [3:0]    so_count,
	input  logic [3:0]    mo_count,
	input  logic          q_valid,
	input  mct_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [39:0]   m_axis_tdata,   // [2:0] out_row, [5:3] out_col, [37:6] out_value
	output logic          m_axis_tlast    // last
);

	import mct_pkg::*;

	localparam int IW    = $clog2(MAX_DIM);
	localparam int CW    = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	function automatic logic [AW-1:0] addr_of(input int unsigned r, input int unsigned c);
		return AW'(r * MAX_DIM + c);
	endfunction

	logic [1:0]    state_q;
	logic          phase_q;   // 0: T = M C, 1: R = C^T T
	logic [CW-1:0] ns_q, nm_q;
	logic [IW-1:0] i_q, j_q, k_q;

	logic [CW-1:0] ns_c, nm_c;
	logic [CW-1:0] i_lim;
	logic          i_last, j_last, k_last;
	logic          finish;

	logic          valid_s1, first_s1, last_s1;
	logic          valid_s2, first_s2, last_s2;
	logic signed [63:0]    prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic          acc_done_q;
	logic signed [31:0]    sat_val;

	logic          out_valid_q;
	logic [2:0]    out_row_q, out_col_q;
	logic [31:0]   out_value_q;
	logic          out_last_q;

	logic          m_we, c_we, p_we;
	logic [AW-1:0] ld_addr;
	logic [AW-1:0] m_rd_addr, c_rd_addr, p_rd_addr, p_wr_addr;
	logic [31:0]   m_rd, c_rd, p_rd;
	logic signed [31:0] op_a, op_b;

	// size clamp, taken at start
	always_comb begin
		if (so_count == 4'd0)
			ns_c = CW'(1);
		else if (32'(so_count) > MAX_DIM)
			ns_c = CW'(MAX_DIM);
		else
			ns_c = CW'(so_count);
		if (mo_count == 4'd0)
			nm_c = CW'(1);
		else if (32'(mo_count) > 32'(ns_c))
			nm_c = ns_c;
		else
			nm_c = CW'(mo_count);
	end

	assign i_lim  = phase_q ? nm_q : ns_q;
	assign i_last = (CW'(i_q) + CW'(1)) == i_lim;
	assign j_last = (CW'(j_q) + CW'(1)) == nm_q;
	assign k_last = (CW'(k_q) + CW'(1)) == ns_q;

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign finish = (state_q == ST_WAIT) && acc_done_q
		&& (!phase_q || !out_valid_q || m_axis_tready);

	// store ports
	assign ld_addr   = addr_of(32'(q_head.row), 32'(q_head.col));
	assign m_we      = q_pop && (q_head.kind == CMD_LOAD_M);
	assign c_we      = q_pop && (q_head.kind == CMD_LOAD_C);
	assign p_we      = finish && !phase_q;
	assign m_rd_addr = addr_of(32'(i_q), 32'(k_q));
	assign c_rd_addr = addr_of(32'(k_q), phase_q ? 32'(i_q) : 32'(j_q));
	assign p_rd_addr = addr_of(32'(k_q), 32'(j_q));
	assign p_wr_addr = addr_of(32'(i_q), 32'(j_q));

	mct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_m_ram (
		.clk(clk), .wr_en(m_we), .wr_addr(ld_addr), .wr_data(q_head.value),
		.rd_addr(m_rd_addr), .rd_data(m_rd)
	);

	mct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_c_ram (
		.clk(clk), .wr_en(c_we), .wr_addr(ld_addr), .wr_data(q_head.value),
		.rd_addr(c_rd_addr), .rd_data(c_rd)
	);

	mct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_p_ram (
		.clk(clk), .wr_en(p_we), .wr_addr(p_wr_addr), .wr_data(sat_val),
		.rd_addr(p_rd_addr), .rd_data(p_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			ns_q    <= CW'(1);
			nm_q    <= CW'(1);
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_head.kind == CMD_START) begin
						ns_q    <= ns_c;
						nm_q    <= nm_c;
						phase_q <= 1'b0;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				ST_WAIT: begin
					if (finish) begin
						state_q <= ST_ISSUE;
						if (!j_last) begin
							j_q <= j_q + IW'(1);
						end else begin
							j_q <= '0;
							if (!i_last) begin
								i_q <= i_q + IW'(1);
							end else begin
								i_q <= '0;
								if (phase_q)
									state_q <= ST_IDLE;
								else
									phase_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// multiply-accumulate pipe: read, multiply, accumulate
	assign op_a = phase_q ? p_rd : m_rd;
	assign op_b = c_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			valid_s2   <= 1'b0;
			first_s2   <= 1'b0;
			last_s2    <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_ISSUE);
			first_s1 <= (k_q == '0);
			last_s1  <= k_last;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (valid_s2 && last_s2)
				acc_done_q <= 1'b1;
			else if (finish)
				acc_done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= op_a * op_b;
		if (valid_s2) begin
			if (first_s2)
				acc_q <= ACC_W'(prod_s2);
			else
				acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign sat_val = sat_shift(acc_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && phase_q) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && phase_q) begin
			out_row_q   <= 3'(i_q);
			out_col_q   <= 3'(j_q);
			out_value_q <= sat_val;
			out_last_q  <= i_last && j_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_value_q, out_col_q, out_row_q};
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_done_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		acc_done_q |-> (state_q == ST_WAIT))
		else $error("accumulator done outside wait state");

	a_last_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |=> acc_done_q)
		else $error("final product did not mark accumulator done");

	a_result_from_r_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(phase_q))
		else $error("result emitted during T phase");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (CW'(k_q) < ns_q))
		else $error("inner index beyond matrix size");
`endif

endmodule

@@ hw/rtl/matrix_congruence_transform_top.sv @@
// Top level of the congruence transform R = C^T M C in signed Q16.16.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: op; tdata: row, col, value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_row, out_col, out_value; tlast
// cfg       in   cfg_valid/cfg_ready          cfg_index: register, cfg_data: value
//
// Load items pass the intake at one per cycle while the queue is not full, into a
// four-entry queue; the engine retires one load per cycle while it is idle. A start item
// occupies the engine through both products: one shared multiply-accumulate walks each
// dot product, one store read per cycle, then the pipe drains and writes back the result.
// Results leave through a one-item output register; a stalled output holds the engine.
// Reset clears control state only; stores hold nothing defined until loaded.
module matrix_congruence_transform_top #(
	parameter int MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	input  logic [39:0] s_axis_tdata,   // [2:0] row, [5:3] col, [37:6] value, rest zero
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [2:0] out_row, [5:3] out_col, [37:6] out_value
	output logic        m_axis_tlast,   // last
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,      // 0 so_count, 1 mo_count
	input  logic [3:0]  cfg_data
);

	import mct_pkg::*;

	logic [3:0] so_count_q;
	logic [3:0] mo_count_q;

	logic q_push, q_full, q_pop, q_valid;
	cmd_t q_cmd, q_head;

	// size registers; writes are taken at any time, used only at start
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			so_count_q <= SIZE_RESET;
			mo_count_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SO_COUNT: so_count_q <= cfg_data;
				REG_MO_COUNT: mo_count_q <= cfg_data;
				default:      so_count_q <= so_count_q;
			endcase
		end
	end

	// intake: decode and filter
	mct_front #(.MAX_DIM(MAX_DIM)) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	// decouples intake from the engine
	mct_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	// stores, MAC engine and result register
	mct_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.so_count      (so_count_q),
		.mo_count      (mo_count_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
